FILE: hw/rtl/shsf_pkg.sv
// shared types and constants for the hopper spring force block
`timescale 1ns / 1ps
package shsf_pkg;

	typedef struct packed {
		logic signed [31:0] x_position;
		logic signed [31:0] z_position;
		logic signed [31:0] z_velocity;
	} in_beat_t;

	typedef struct packed {
		logic signed [31:0] force_x;
		logic signed [31:0] force_z;
		logic               stance_flag;
		logic               unstable_flag;
	} out_beat_t;

	localparam logic [1:0] REG_REST_LENGTH      = 2'd0;
	localparam logic [1:0] REG_SPRING_STIFFNESS = 2'd1;
	localparam logic [1:0] REG_TOUCHDOWN_HEIGHT = 2'd2;
	localparam logic [1:0] REG_FOOT_OFFSET      = 2'd3;

	localparam logic [20:0] RESET_REST_LENGTH      = 21'd65536;
	localparam logic [15:0] RESET_SPRING_STIFFNESS = 16'd25000;
	localparam logic [20:0] RESET_TOUCHDOWN_HEIGHT = 21'd62705;
	localparam logic [20:0] RESET_FOOT_OFFSET      = 21'd19052;

	// sqrt result bits and divide dividend bits
	// the sum of squares stays below 2^66, so the root never reaches bit 33
	localparam int SQRT_BITS = 33;
	localparam int DIV_BITS  = 87;
	localparam logic [40:0] Q_CAP = 41'h100_0000_0000;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PHASE,
		ST_SQ_A,
		ST_SQ_B,
		ST_SQRT,
		ST_MUL_M,
		ST_PROD_X,
		ST_DIV_X,
		ST_PROD_Z,
		ST_DIV_Z,
		ST_FINISH,
		ST_OUT
	} state_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_PHASE,
		CMD_SQ_A,
		CMD_SQ_B,
		CMD_SQRT,
		CMD_MUL_M,
		CMD_PROD_X,
		CMD_PROD_HI,
		CMD_DIV,
		CMD_SAVE_X,
		CMD_PROD_Z,
		CMD_FINISH
	} cmd_t;

	typedef struct packed {
		cmd_t       cmd;
	} ctl_t;

	typedef struct packed {
		logic stance;
		logic zero_len;
	} sts_t;

endpackage

FILE: hw/rtl/shsf_datapath.sv
// datapath: phase logic, leg length square root and force division
`timescale 1ns / 1ps
module shsf_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  shsf_pkg::in_beat_t  in_beat,
	input  shsf_pkg::ctl_t    ctl,
	input  logic [20:0]       rest_length,
	input  logic [15:0]       spring_stiffness,
	input  logic [20:0]       touchdown_height,
	input  logic [20:0]       foot_offset,
	output shsf_pkg::sts_t    sts,
	output shsf_pkg::out_beat_t result
);
	import shsf_pkg::*;

	logic               in_stance_q, armed_q;
	logic signed [31:0] foot_x_q;
	logic [1:0]         prev_sign_q;
	logic signed [31:0] x_q, z_q, v_q;
	logic [32:0]        adx_q, az_q;
	logic               dx_neg_q, z_neg_q;
	logic [66:0]        sumsq_q;
	logic [34:0]        root_q;
	logic [5:0]         bit_q;
	logic [50:0]        m_q;
	logic [32:0]        opnd_q;
	logic               diff_neg_q;
	logic [86:0]        num_q;
	logic [35:0]        rem_q;
	logic [40:0]        quo_q;
	logic signed [31:0] fx_q, fz_q;
	logic               unstable_q;

	logic [1:0]  sv;
	logic signed [33:0] dx_w, fx_sum;
	logic [34:0] cand;
	logic [65:0] cand_sq;
	logic [36:0] rem_sh;
	logic [40:0] quo_nx;
	logic [32:0] prod_opnd;
	logic signed [31:0] force_sat;
	logic        neg_sel;

	always_comb begin
		sv = (v_q == 32'sd0) ? 2'b00 : (v_q[31] ? 2'b11 : 2'b01);
		dx_w = 34'(x_q) - 34'(foot_x_q);
		fx_sum = 34'(x_q) + 34'(signed'({1'b0, foot_offset}));
		cand = root_q | (35'd1 << bit_q);
		cand_sq = 66'(cand[32:0]) * 66'(cand[32:0]);
		rem_sh = {rem_q, num_q[86]};
		quo_nx = {quo_q[39:0], 1'b0};
		if (rem_sh >= 37'(root_q)) quo_nx[0] = 1'b1;
		prod_opnd = (ctl.cmd == CMD_PROD_X) ? adx_q : az_q;
		neg_sel = diff_neg_q ^ (ctl.cmd == CMD_SAVE_X ? dx_neg_q : z_neg_q);
		if (neg_sel) force_sat = (quo_q > 41'd2147483648) ? 32'sh8000_0000 : -32'(quo_q);
		else force_sat = (quo_q > 41'd2147483647) ? 32'sh7fff_ffff : 32'(quo_q);
	end

	// |l0-l| may exceed 21 bits when l is large
	logic [34:0] absdiff;
	always_comb begin
		absdiff = (root_q > 35'(rest_length)) ? root_q - 35'(rest_length)
			: 35'(rest_length) - root_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_stance_q <= 1'b0;
			armed_q <= 1'b1;
			foot_x_q <= '0;
			prev_sign_q <= 2'b11;
		end else if (ctl.cmd == CMD_PHASE) begin
			prev_sign_q <= sv;
			if (!in_stance_q) begin
				if (sv != prev_sign_q && z_q > 32'sd0 + 32'(foot_offset) && !z_q[31])
					armed_q <= 1'b1;
				if (v_q[31] && (z_q[31] || z_q <= 32'(touchdown_height))
					&& (armed_q || (sv != prev_sign_q && !z_q[31]
					&& z_q > 32'(foot_offset)))) begin
					foot_x_q <= (fx_sum > 34'sd2147483647) ? 32'sh7fff_ffff : 32'(fx_sum);
					in_stance_q <= 1'b1;
				end
			end
		end else if (ctl.cmd == CMD_MUL_M && root_q >= 35'(rest_length)) begin
			in_stance_q <= 1'b0;
			armed_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctl.cmd)
			CMD_LOAD: begin
				x_q <= in_beat.x_position;
				z_q <= in_beat.z_position;
				v_q <= in_beat.z_velocity;
				fx_q <= '0;
				fz_q <= '0;
			end
			CMD_PHASE: begin
				unstable_q <= !in_stance_q && !(v_q[31]
					&& (z_q[31] || z_q <= 32'(touchdown_height))
					&& (armed_q || (sv != prev_sign_q && !z_q[31]
					&& z_q > 32'(foot_offset))))
					&& (z_q[31] || z_q < 32'(touchdown_height));
				adx_q <= dx_w[33] ? 33'(-dx_w) : 33'(dx_w);
				dx_neg_q <= dx_w[33];
				az_q <= z_q[31] ? 33'(-34'(z_q)) : 33'(z_q);
				z_neg_q <= z_q[31];
			end
			CMD_SQ_A: sumsq_q <= 67'(adx_q * adx_q);
			CMD_SQ_B: begin
				sumsq_q <= sumsq_q + 67'(az_q * az_q);
				root_q <= '0;
				bit_q <= 6'(SQRT_BITS - 1);
			end
			CMD_SQRT: begin
				if (67'(cand_sq) <= sumsq_q) root_q <= cand;
				bit_q <= bit_q - 6'd1;
			end
			CMD_MUL_M: begin
				m_q <= 51'(absdiff) * 51'(spring_stiffness);
				diff_neg_q <= root_q > 35'(rest_length);
			end
			// product in two partial steps: low 32 bits of m, then the high bits
			CMD_PROD_X, CMD_PROD_Z: begin
				opnd_q <= prod_opnd;
				num_q <= 87'(m_q[31:0]) * 87'(prod_opnd);
				rem_q <= '0;
				quo_q <= '0;
				bit_q <= 6'd0;
			end
			CMD_PROD_HI: num_q <= num_q + ((87'(m_q[50:32]) * 87'(opnd_q)) << 32);
			CMD_DIV: begin
				rem_q <= (rem_sh >= 37'(root_q)) ? 36'(rem_sh - 37'(root_q)) : 36'(rem_sh);
				quo_q <= (quo_q[40] || quo_nx > Q_CAP) ? Q_CAP : quo_nx;
				num_q <= {num_q[85:0], 1'b0};
			end
			CMD_SAVE_X: if (root_q != '0) fx_q <= force_sat;
			CMD_FINISH: if (root_q != '0) fz_q <= force_sat;
			default: ;
		endcase
	end

	assign sts.stance = in_stance_q;
	assign sts.zero_len = (root_q == '0);
	assign result.force_x = fx_q;
	assign result.force_z = fz_q;
	assign result.stance_flag = in_stance_q;
	assign result.unstable_flag = in_stance_q ? 1'b0 : unstable_q;
endmodule

FILE: hw/rtl/shsf_ctrl.sv
// controller: sequences one sample through the datapath
`timescale 1ns / 1ps
module shsf_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  logic            out_stall,
	input  shsf_pkg::sts_t  sts,
	output shsf_pkg::ctl_t  ctl
);
	import shsf_pkg::*;

	state_t state_q, state_nx;
	logic [6:0] cnt_q, cnt_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_nx;
			cnt_q <= cnt_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		cnt_nx = cnt_q;
		ctl.cmd = CMD_NONE;
		in_stall = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					ctl.cmd = CMD_LOAD;
					state_nx = ST_PHASE;
				end
			end
			ST_PHASE: begin
				ctl.cmd = CMD_PHASE;
				state_nx = sts.stance ? ST_SQ_A : ST_OUT;
			end
			ST_SQ_A: begin
				ctl.cmd = CMD_SQ_A;
				state_nx = ST_SQ_B;
			end
			ST_SQ_B: begin
				ctl.cmd = CMD_SQ_B;
				cnt_nx = 7'(SQRT_BITS - 1);
				state_nx = ST_SQRT;
			end
			ST_SQRT: begin
				ctl.cmd = CMD_SQRT;
				cnt_nx = cnt_q - 7'd1;
				if (cnt_q == '0) state_nx = ST_MUL_M;
			end
			ST_MUL_M: begin
				ctl.cmd = CMD_MUL_M;
				state_nx = sts.zero_len ? ST_OUT : ST_PROD_X;
			end
			ST_PROD_X: begin
				ctl.cmd = CMD_PROD_X;
				cnt_nx = 7'(DIV_BITS);
				state_nx = ST_DIV_X;
			end
			ST_DIV_X: begin
				// adds the high partial product first, then divides
				ctl.cmd = (cnt_q == 7'(DIV_BITS)) ? CMD_PROD_HI : CMD_DIV;
				cnt_nx = cnt_q - 7'd1;
				if (cnt_q == '0) state_nx = ST_PROD_Z;
			end
			ST_PROD_Z: begin
				ctl.cmd = CMD_SAVE_X;
				state_nx = ST_DIV_Z;
				cnt_nx = 7'(DIV_BITS + 1);
			end
			ST_DIV_Z: begin
				// loads the low, then the high partial product, then divides
				if (cnt_q == 7'(DIV_BITS + 1)) ctl.cmd = CMD_PROD_Z;
				else if (cnt_q == 7'(DIV_BITS)) ctl.cmd = CMD_PROD_HI;
				else ctl.cmd = CMD_DIV;
				cnt_nx = cnt_q - 7'd1;
				if (cnt_q == '0) state_nx = ST_FINISH;
			end
			ST_FINISH: begin
				ctl.cmd = CMD_FINISH;
				state_nx = ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end
endmodule

FILE: hw/rtl/slip_hopper_spring_force.sv
// top level: spring leg force per body sample, with configuration registers
//  channel | signals                          | beat
//  in      | in_valid, in_stall, in_data      | one body sample
//  out     | out_valid, out_stall, out_data   | forces and phase flags
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | one register write
// flight samples go through load, phase and output before the next accept;
// stance samples go through the 33-step square root and two 87-step restoring
// divisions, each after a product in low and high parts; zero leg length skips them.
// reset puts the leg in flight, armed, foot at zero, registers at defaults.
// a stalled result holds the block; the next sample is taken after delivery.
`timescale 1ns / 1ps
module slip_hopper_spring_force (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  shsf_pkg::in_beat_t     in_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output shsf_pkg::out_beat_t    out_data,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [1:0]             cfg_index,
	input  logic [31:0]            cfg_data
);
	import shsf_pkg::*;

	logic [20:0] rest_length_q, touchdown_height_q, foot_offset_q;
	logic [15:0] spring_stiffness_q;
	ctl_t ctl;
	sts_t sts;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rest_length_q <= RESET_REST_LENGTH;
			spring_stiffness_q <= RESET_SPRING_STIFFNESS;
			touchdown_height_q <= RESET_TOUCHDOWN_HEIGHT;
			foot_offset_q <= RESET_FOOT_OFFSET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_REST_LENGTH:      rest_length_q <= cfg_data[20:0];
				REG_SPRING_STIFFNESS: spring_stiffness_q <= cfg_data[15:0];
				REG_TOUCHDOWN_HEIGHT: touchdown_height_q <= cfg_data[20:0];
				REG_FOOT_OFFSET:      foot_offset_q <= cfg_data[20:0];
				default: ;
			endcase
		end
	end

	shsf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall),
		.sts(sts), .ctl(ctl)
	);

	shsf_datapath u_dp (
		.clk(clk), .arst_n(arst_n),
		.in_beat(in_data), .ctl(ctl),
		.rest_length(rest_length_q), .spring_stiffness(spring_stiffness_q),
		.touchdown_height(touchdown_height_q), .foot_offset(foot_offset_q),
		.sts(sts), .result(out_data)
	);
endmodule
